// File: src/oocs_pkg.sv
// Shared types, codes and field widths for the observatory open/close sequencer.
// No dependencies; every other source file imports this package.
`timescale 1ns / 1ps

package oocs_pkg;

   localparam int TIME_W = 17;

   // request kinds
   localparam logic [1:0] KIND_TICK = 2'd0;
   localparam logic [1:0] KIND_ACTION = 2'd1;
   localparam logic [1:0] KIND_HOME = 2'd2;

   // user actions
   localparam logic [2:0] ACT_OPEN = 3'd0;
   localparam logic [2:0] ACT_CLOSE = 3'd1;
   localparam logic [2:0] ACT_AUTO = 3'd2;
   localparam logic [2:0] ACT_ABORT = 3'd3;
   localparam logic [2:0] ACT_IDLE = 3'd4;

   // modes
   localparam logic [2:0] MODE_IDLE = 3'd0;
   localparam logic [2:0] MODE_OPEN = 3'd1;
   localparam logic [2:0] MODE_CLOSE = 3'd2;
   localparam logic [2:0] MODE_AUTO = 3'd3;
   localparam logic [2:0] MODE_ABORT = 3'd4;

   // phases
   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_OPEN_DOME = 4'd1;
   localparam logic [3:0] PH_WAIT_DOME_OPEN = 4'd2;
   localparam logic [3:0] PH_UNPARK = 4'd3;
   localparam logic [3:0] PH_WAIT_UNPARK = 4'd4;
   localparam logic [3:0] PH_START_TRACK = 4'd5;
   localparam logic [3:0] PH_MONITOR = 4'd6;
   localparam logic [3:0] PH_STOP_TRACK = 4'd7;
   localparam logic [3:0] PH_GO_HOME = 4'd8;
   localparam logic [3:0] PH_WAIT_HOME = 4'd9;
   localparam logic [3:0] PH_PARK = 4'd10;
   localparam logic [3:0] PH_WAIT_PARK = 4'd11;
   localparam logic [3:0] PH_CLOSE_DOME = 4'd12;
   localparam logic [3:0] PH_WAIT_DOME_CLOSE = 4'd13;
   localparam logic [3:0] PH_EMERGENCY = 4'd14;

   // device commands
   localparam logic [3:0] CMD_NONE = 4'd0;
   localparam logic [3:0] CMD_SHUTTER_OPEN = 4'd1;
   localparam logic [3:0] CMD_SHUTTER_CLOSE = 4'd2;
   localparam logic [3:0] CMD_UNPARK = 4'd3;
   localparam logic [3:0] CMD_PARK = 4'd4;
   localparam logic [3:0] CMD_TRACK_ON = 4'd5;
   localparam logic [3:0] CMD_TRACK_OFF = 4'd6;
   localparam logic [3:0] CMD_GO_HOME = 4'd7;
   localparam logic [3:0] CMD_ABORT_MOUNT = 4'd8;
   localparam logic [3:0] CMD_ABORT_DOME = 4'd9;

   // warnings
   localparam logic [1:0] WARN_NONE = 2'd0;
   localparam logic [1:0] WARN_WEATHER_REFUSED = 2'd1;
   localparam logic [1:0] WARN_NO_DEVICES = 2'd2;
   localparam logic [1:0] WARN_WEATHER_CLOSING = 2'd3;

   // time window rules
   localparam logic [1:0] RULE_NONE = 2'd0;
   localparam logic [1:0] RULE_ANYTIME = 2'd1;
   localparam logic [1:0] RULE_DUSK_DAWN = 2'd2;
   localparam logic [1:0] RULE_FIXED = 2'd3;

   // configuration register indexes
   localparam logic [2:0] REG_HAS_DOME = 3'd0;
   localparam logic [2:0] REG_HAS_MOUNT = 3'd1;
   localparam logic [2:0] REG_WEATHER_MUST_BE_OK = 3'd2;
   localparam logic [2:0] REG_TIME_RULE = 3'd3;
   localparam logic [2:0] REG_FIXED_START = 3'd4;
   localparam logic [2:0] REG_FIXED_END = 3'd5;

   typedef struct packed {
      logic              has_dome;
      logic              has_mount;
      logic              weather_must_be_ok;
      logic [1:0]        time_rule;
      logic [TIME_W-1:0] fixed_start;
      logic [TIME_W-1:0] fixed_end;
   } cfg_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] phase;
      logic       mount_home;
   } state_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [2:0]        action;
      logic              shutter_closed;
      logic              mount_parked;
      logic              weather_ok;
      logic [TIME_W-1:0] time_now;
      logic [TIME_W-1:0] sunset_time;
      logic [TIME_W-1:0] sunrise_time;
   } req_type;

   // what one request produces: one or two commands plus status
   typedef struct packed {
      logic [3:0] cmd_first;
      logic [3:0] cmd_second;
      logic       two;
      logic [3:0] phase;
      logic [2:0] mode;
      logic [1:0] warning;
   } step_out_type;

   typedef struct packed {
      logic [3:0] command;
      logic [3:0] phase;
      logic [2:0] mode;
      logic [1:0] warning;
   } rsp_item_type;

endpackage

// File: src/oocs_step.sv
// Next-state and command logic for one request of the sequencer.
// Depends on oocs_pkg; purely combinational.
`timescale 1ns / 1ps

module oocs_step
   import oocs_pkg::*;
(
   input  cfg_type      cfg,
   input  state_type    state,
   input  req_type      req,
   output state_type    state_next,
   output step_out_type result
);

   function automatic logic in_window(input logic [TIME_W-1:0] now,
                                      input logic [TIME_W-1:0] start,
                                      input logic [TIME_W-1:0] stop);
      if (start <= stop) begin
         return (now >= start) && (now < stop);
      end
      return (now >= start) || (now < stop);
   endfunction

   always_comb begin
      logic [2:0] m;
      logic [3:0] p;
      logic       h;
      logic [1:0] w;
      logic [3:0] c0;
      logic [3:0] c1;
      logic       two;
      logic       want;

      m = state.mode;
      p = state.phase;
      h = state.mount_home;
      w = WARN_NONE;
      c0 = CMD_NONE;
      c1 = CMD_NONE;
      two = 1'b0;
      want = 1'b0;

      case (req.kind)
         KIND_TICK: begin
            // auto window rule, then one phase step on the updated phase
            if (m == MODE_AUTO && (p == PH_IDLE || p == PH_MONITOR)) begin
               case (cfg.time_rule)
                  RULE_ANYTIME:   want = 1'b1;
                  RULE_DUSK_DAWN: want = in_window(req.time_now, req.sunset_time,
                                                   req.sunrise_time);
                  RULE_FIXED:     want = in_window(req.time_now, cfg.fixed_start,
                                                   cfg.fixed_end);
                  default:        want = 1'b0;
               endcase
               if (want && p == PH_IDLE) begin
                  if (cfg.weather_must_be_ok && !req.weather_ok) begin
                     w = WARN_WEATHER_REFUSED;
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end else if (cfg.has_dome) begin
                     p = PH_OPEN_DOME;
                  end else if (cfg.has_mount) begin
                     p = PH_UNPARK;
                  end else begin
                     w = WARN_NO_DEVICES;
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end
               end else if (!want && p == PH_MONITOR) begin
                  if (cfg.has_mount) begin
                     p = PH_STOP_TRACK;
                  end else if (cfg.has_dome) begin
                     p = PH_CLOSE_DOME;
                  end else begin
                     w = WARN_NO_DEVICES;
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end
               end
            end

            case (p)
               PH_IDLE: begin
               end
               PH_OPEN_DOME: begin
                  c0 = CMD_SHUTTER_OPEN;
                  p = PH_WAIT_DOME_OPEN;
               end
               PH_WAIT_DOME_OPEN: begin
                  if (!req.shutter_closed) begin
                     p = cfg.has_mount ? PH_UNPARK : PH_MONITOR;
                  end
               end
               PH_UNPARK: begin
                  c0 = CMD_UNPARK;
                  p = PH_WAIT_UNPARK;
               end
               PH_WAIT_UNPARK: begin
                  if (!req.mount_parked) begin
                     p = PH_START_TRACK;
                  end
               end
               PH_START_TRACK: begin
                  c0 = CMD_TRACK_ON;
                  h = 1'b1;
                  p = PH_MONITOR;
               end
               PH_MONITOR: begin
                  if (cfg.weather_must_be_ok && !req.weather_ok) begin
                     w = WARN_WEATHER_CLOSING;
                     m = MODE_CLOSE;
                     if (cfg.has_mount) begin
                        p = PH_STOP_TRACK;
                     end else if (cfg.has_dome) begin
                        p = PH_CLOSE_DOME;
                     end else begin
                        w = WARN_NO_DEVICES;
                        m = MODE_IDLE;
                        p = PH_IDLE;
                     end
                  end
               end
               PH_STOP_TRACK: begin
                  c0 = CMD_TRACK_OFF;
                  p = PH_GO_HOME;
               end
               PH_GO_HOME: begin
                  h = 1'b0;
                  c0 = CMD_GO_HOME;
                  p = PH_WAIT_HOME;
               end
               PH_WAIT_HOME: begin
                  if (h) begin
                     p = PH_PARK;
                  end
               end
               PH_PARK: begin
                  c0 = CMD_PARK;
                  p = PH_WAIT_PARK;
               end
               PH_WAIT_PARK: begin
                  if (req.mount_parked) begin
                     if (cfg.has_dome) begin
                        p = PH_CLOSE_DOME;
                     end else begin
                        m = MODE_IDLE;
                        p = PH_IDLE;
                     end
                  end
               end
               PH_CLOSE_DOME: begin
                  c0 = CMD_SHUTTER_CLOSE;
                  p = PH_WAIT_DOME_CLOSE;
               end
               PH_WAIT_DOME_CLOSE: begin
                  if (req.shutter_closed) begin
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end
               end
               PH_EMERGENCY: begin
                  // mount abort goes first when both devices are present
                  if (cfg.has_mount && cfg.has_dome) begin
                     c0 = CMD_ABORT_MOUNT;
                     c1 = CMD_ABORT_DOME;
                     two = 1'b1;
                  end else if (cfg.has_mount) begin
                     c0 = CMD_ABORT_MOUNT;
                  end else if (cfg.has_dome) begin
                     c0 = CMD_ABORT_DOME;
                  end
                  m = MODE_IDLE;
                  p = PH_IDLE;
               end
               default: begin
                  p = PH_IDLE;
               end
            endcase
         end

         KIND_ACTION: begin
            case (req.action)
               ACT_OPEN: begin
                  m = MODE_OPEN;
                  if (cfg.weather_must_be_ok && !req.weather_ok) begin
                     w = WARN_WEATHER_REFUSED;
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end else if (cfg.has_dome) begin
                     p = PH_OPEN_DOME;
                  end else if (cfg.has_mount) begin
                     p = PH_UNPARK;
                  end else begin
                     w = WARN_NO_DEVICES;
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end
               end
               ACT_CLOSE: begin
                  m = MODE_CLOSE;
                  if (cfg.has_mount) begin
                     p = PH_STOP_TRACK;
                  end else if (cfg.has_dome) begin
                     p = PH_CLOSE_DOME;
                  end else begin
                     w = WARN_NO_DEVICES;
                     m = MODE_IDLE;
                     p = PH_IDLE;
                  end
               end
               ACT_AUTO: begin
                  m = MODE_AUTO;
                  p = PH_IDLE;
               end
               ACT_ABORT: begin
                  m = MODE_ABORT;
                  p = PH_EMERGENCY;
               end
               ACT_IDLE: begin
                  m = MODE_IDLE;
                  p = PH_IDLE;
               end
               default: begin
               end
            endcase
         end

         KIND_HOME: begin
            if (cfg.has_mount) begin
               h = 1'b1;
            end
         end

         default: begin
         end
      endcase

      state_next.mode = m;
      state_next.phase = p;
      state_next.mount_home = h;
      result.cmd_first = c0;
      result.cmd_second = c1;
      result.two = two;
      result.phase = p;
      result.mode = m;
      result.warning = w;
   end

endmodule

// File: src/oocs_rsp_buf.sv
// Response register for the sequencer: holds the one or two responses of a request.
// Depends on oocs_pkg.
`timescale 1ns / 1ps

module oocs_rsp_buf
   import oocs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  step_out_type result,
   output logic         free,
   output logic         rsp_valid,
   output logic         rsp_last,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic [1:0]   count_ff, count_in;
   rsp_item_type head_ff, head_in;
   logic [3:0]   second_ff, second_in;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_last = (count_ff == 2'd1);
   assign rsp_item = head_ff;
   // room for a new request once the final response leaves
   assign free = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   always_comb begin
      count_in = count_ff;
      head_in = head_ff;
      second_in = second_ff;
      if (load) begin
         count_in = result.two ? 2'd2 : 2'd1;
         head_in.command = result.cmd_first;
         head_in.phase = result.phase;
         head_in.mode = result.mode;
         head_in.warning = result.warning;
         second_in = result.cmd_second;
      end else if (rsp_valid && rsp_ready) begin
         if (count_ff == 2'd2) begin
            count_in = 2'd1;
            head_in.command = second_ff;
         end else begin
            count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      second_ff <= second_in;
   end

endmodule

// File: src/observatory_open_close_sequencer.sv
// Top level of the observatory open/close sequencer: request register, state,
// configuration registers. Depends on oocs_pkg, oocs_step and oocs_rsp_buf.
`timescale 1ns / 1ps

// Sequences a dome shutter and a telescope mount through opening and closing.
// Each request (a timer tick with device status, weather and times of day, a
// user action, or a mount-home event) yields one response, or two for an
// emergency abort tick with both devices present; the last response of a
// request carries rsp_tlast. One request is accepted per clock cycle while the
// response register has room; a request with two responses holds the response
// port until both are taken. The request is registered, then the step logic
// updates the state and loads the response register. The pace is set by the
// response register, which takes a new request as its final response leaves.
// Configuration writes are always accepted (csr_ready is tied high) and must
// only be issued while no request is in flight. After reset the mode and
// phase are idle, the mount-at-home flag is clear and the configuration is zero.
module observatory_open_close_sequencer
   import oocs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: action[2:0], shutter_closed[3], mount_parked[4], weather_ok[5],
   //        time_now[22:6], sunset_time[39:23], sunrise_time[56:40], zero[63:57]
   input  logic [63:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: command[3:0], phase_now[7:4], mode_now[10:8], warning[12:11],
   //        zero[15:13]
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [16:0] csr_data
);

   cfg_type      cfg_ff, cfg_in;
   state_type    state_ff, state_in;
   state_type    state_next;
   logic         req_valid_ff, req_valid_in;
   req_type      req_ff, req_in;
   step_out_type step_result;
   logic         buf_free;
   logic         consume;
   rsp_item_type rsp_item;

   assign csr_ready = 1'b1;

   // configuration registers; indexes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_HAS_DOME:           cfg_in.has_dome = csr_data[0];
            REG_HAS_MOUNT:          cfg_in.has_mount = csr_data[0];
            REG_WEATHER_MUST_BE_OK: cfg_in.weather_must_be_ok = csr_data[0];
            REG_TIME_RULE:          cfg_in.time_rule = csr_data[1:0];
            REG_FIXED_START:        cfg_in.fixed_start = csr_data;
            REG_FIXED_END:          cfg_in.fixed_end = csr_data;
            default: begin
            end
         endcase
      end
   end

   // the registered request advances once the response register has room
   assign consume = req_valid_ff && buf_free;
   assign req_tready = !req_valid_ff || buf_free;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_in = req_ff;
      if (req_tready) begin
         req_valid_in = req_tvalid;
         req_in.kind = req_tuser;
         req_in.action = req_tdata[2:0];
         req_in.shutter_closed = req_tdata[3];
         req_in.mount_parked = req_tdata[4];
         req_in.weather_ok = req_tdata[5];
         req_in.time_now = req_tdata[22:6];
         req_in.sunset_time = req_tdata[39:23];
         req_in.sunrise_time = req_tdata[56:40];
      end
   end

   oocs_step u_step (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .req        (req_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   // commit the new state together with loading the response
   assign state_in = consume ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         state_ff.mode <= MODE_IDLE;
         state_ff.phase <= PH_IDLE;
         state_ff.mount_home <= 1'b0;
         req_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         state_ff <= state_in;
         req_valid_ff <= req_valid_in;
      end
      req_ff <= req_in;
   end

   oocs_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (consume),
      .result    (step_result),
      .free      (buf_free),
      .rsp_valid (rsp_tvalid),
      .rsp_last  (rsp_tlast),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {3'b000, rsp_item.warning, rsp_item.mode, rsp_item.phase,
                       rsp_item.command};

endmodule

// File: src/oocs_checker.sv
// Port-level checks for the observatory open/close sequencer, bound to the top.
// Depends on oocs_pkg and observatory_open_close_sequencer.
`timescale 1ns / 1ps

module oocs_checker
   import oocs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // only a double abort has a response before the last one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[3:0] == CMD_ABORT_MOUNT)
      else $error("non-final response is not a mount abort");

   // the second abort response follows at once
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast
         && rsp_tdata[3:0] == CMD_ABORT_DOME)
      else $error("second abort response missing");

   // a shutter-open command leaves the sequence waiting for the dome
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3:0] == CMD_SHUTTER_OPEN |-> rsp_tdata[7:4] == PH_WAIT_DOME_OPEN)
      else $error("shutter open without wait phase");

   // an abort command always lands in idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:0] == CMD_ABORT_MOUNT || rsp_tdata[3:0] == CMD_ABORT_DOME)
         |-> rsp_tdata[7:4] == PH_IDLE && rsp_tdata[10:8] == MODE_IDLE)
      else $error("abort did not return to idle");

endmodule

bind observatory_open_close_sequencer oocs_checker u_oocs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/testbench.sv
// Self-checking testbench for the observatory open/close sequencer.
// Depends on oocs_pkg and the sequencer RTL; all responses checked, predicted or pinned.
`timescale 1ns / 1ps

module testbench;
   import oocs_pkg::*;

   // codes the package leaves unnamed: the block must ignore them
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [2:0] ACT_UNUSED_MIN = 3'd5;
   localparam logic [2:0] ACT_UNUSED_MAX = 3'd7;

   localparam logic [TIME_W-1:0] TIME_ALL_ONES = '1;
   localparam int DAY_LAST = 86399;
   localparam int SETTING_COUNT = 8;
   localparam int ITEMS_PER_SETTING = 125;
   localparam int SETUP_ROW = 8;        // directed row that first runs with devices present
   localparam int QUIET_LIMIT = 200;    // cycles with no handshake before giving up
   localparam int TAIL_CYCLES = 8;      // margin for the last responses
   localparam int REPORT_CAP = 20;

   typedef struct packed {
      logic [3:0] command;
      logic       last;
      logic [3:0] phase;
      logic [2:0] mode;
      logic [1:0] warning;
   } status_type;

   typedef struct {
      req_type    r;
      bit         pinned;      // expected response typed in below instead of predicted
      status_type want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [16:0] csr_data;

   observatory_open_close_sequencer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Predictor state: our own copy of the registers, mode, phase and home flag.
   cfg_type     model_cfg;
   logic [2:0]  seq_mode;
   logic [3:0]  seq_phase;
   logic        seq_home;
   logic [3:0]  step_cmds[$];
   logic [1:0]  step_warn;

   status_type   awaited_status[$];   // responses still owed by the block
   plan_row_type rows[$];

   bit          calm;                // no idling on either side while set
   int          rsp_hold;
   int          mismatches;
   int          checked_count;
   int          directed_count;
   int          random_count;
   int          settings_count;
   bit          seen_cmd[16];
   bit          seen_phase[16];

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic bit in_span(logic [TIME_W-1:0] now, logic [TIME_W-1:0] lo,
                                  logic [TIME_W-1:0] hi);
      // a span with lo above hi wraps past midnight
      if (lo <= hi)
         return now >= lo && now < hi;
      return now >= lo || now < hi;
   endfunction

   function automatic void go_idle();
      seq_mode = MODE_IDLE;
      seq_phase = PH_IDLE;
   endfunction

   function automatic void begin_opening(logic wx_ok);
      if (model_cfg.weather_must_be_ok && !wx_ok) begin
         step_warn = WARN_WEATHER_REFUSED;
         go_idle();
      end else if (model_cfg.has_dome) begin
         seq_phase = PH_OPEN_DOME;
      end else if (model_cfg.has_mount) begin
         seq_phase = PH_UNPARK;
      end else begin
         step_warn = WARN_NO_DEVICES;
         go_idle();
      end
   endfunction

   function automatic void begin_closing();
      if (model_cfg.has_mount) begin
         seq_phase = PH_STOP_TRACK;
      end else if (model_cfg.has_dome) begin
         seq_phase = PH_CLOSE_DOME;
      end else begin
         step_warn = WARN_NO_DEVICES;
         go_idle();
      end
   endfunction

   // Advance the predicted sequencer by one request; queue its responses when keep is set.
   function automatic void predict_request(req_type r, bit keep);
      logic       want;
      int         n;
      status_type s;
      step_cmds.delete();
      step_warn = WARN_NONE;
      want = 1'b0;
      case (r.kind)
         KIND_TICK: begin
            // the auto window rule runs first, then one phase step
            if (seq_mode == MODE_AUTO && (seq_phase == PH_IDLE || seq_phase == PH_MONITOR)) begin
               case (model_cfg.time_rule)
                  RULE_ANYTIME:   want = 1'b1;
                  RULE_DUSK_DAWN: want = in_span(r.time_now, r.sunset_time, r.sunrise_time);
                  RULE_FIXED:     want = in_span(r.time_now, model_cfg.fixed_start,
                                                 model_cfg.fixed_end);
                  default:        want = 1'b0;
               endcase
               if (want && seq_phase == PH_IDLE)
                  begin_opening(r.weather_ok);
               else if (!want && seq_phase == PH_MONITOR)
                  begin_closing();
            end
            case (seq_phase)
               PH_OPEN_DOME: begin
                  step_cmds.push_back(CMD_SHUTTER_OPEN);
                  seq_phase = PH_WAIT_DOME_OPEN;
               end
               PH_WAIT_DOME_OPEN: begin
                  if (!r.shutter_closed)
                     seq_phase = model_cfg.has_mount ? PH_UNPARK : PH_MONITOR;
               end
               PH_UNPARK: begin
                  step_cmds.push_back(CMD_UNPARK);
                  seq_phase = PH_WAIT_UNPARK;
               end
               PH_WAIT_UNPARK: begin
                  if (!r.mount_parked)
                     seq_phase = PH_START_TRACK;
               end
               PH_START_TRACK: begin
                  step_cmds.push_back(CMD_TRACK_ON);
                  seq_home = 1'b1;
                  seq_phase = PH_MONITOR;
               end
               PH_MONITOR: begin
                  if (model_cfg.weather_must_be_ok && !r.weather_ok) begin
                     step_warn = WARN_WEATHER_CLOSING;
                     seq_mode = MODE_CLOSE;
                     begin_closing();
                  end
               end
               PH_STOP_TRACK: begin
                  step_cmds.push_back(CMD_TRACK_OFF);
                  seq_phase = PH_GO_HOME;
               end
               PH_GO_HOME: begin
                  seq_home = 1'b0;
                  step_cmds.push_back(CMD_GO_HOME);
                  seq_phase = PH_WAIT_HOME;
               end
               PH_WAIT_HOME: begin
                  if (seq_home)
                     seq_phase = PH_PARK;
               end
               PH_PARK: begin
                  step_cmds.push_back(CMD_PARK);
                  seq_phase = PH_WAIT_PARK;
               end
               PH_WAIT_PARK: begin
                  if (r.mount_parked) begin
                     if (model_cfg.has_dome)
                        seq_phase = PH_CLOSE_DOME;
                     else
                        go_idle();
                  end
               end
               PH_CLOSE_DOME: begin
                  step_cmds.push_back(CMD_SHUTTER_CLOSE);
                  seq_phase = PH_WAIT_DOME_CLOSE;
               end
               PH_WAIT_DOME_CLOSE: begin
                  if (r.shutter_closed)
                     go_idle();
               end
               PH_EMERGENCY: begin
                  if (model_cfg.has_mount)
                     step_cmds.push_back(CMD_ABORT_MOUNT);
                  if (model_cfg.has_dome)
                     step_cmds.push_back(CMD_ABORT_DOME);
                  go_idle();
               end
               PH_IDLE: ;
               default: seq_phase = PH_IDLE;
            endcase
         end
         KIND_ACTION: begin
            case (r.action)
               ACT_OPEN: begin
                  seq_mode = MODE_OPEN;
                  begin_opening(r.weather_ok);
               end
               ACT_CLOSE: begin
                  seq_mode = MODE_CLOSE;
                  begin_closing();
               end
               ACT_AUTO: begin
                  seq_mode = MODE_AUTO;
                  seq_phase = PH_IDLE;
               end
               ACT_ABORT: begin
                  seq_mode = MODE_ABORT;
                  seq_phase = PH_EMERGENCY;
               end
               ACT_IDLE: go_idle();
               default: ;
            endcase
         end
         KIND_HOME: begin
            if (model_cfg.has_mount)
               seq_home = 1'b1;
         end
         default: ;
      endcase
      if (keep) begin
         // one response per request, or one per command when there are several
         n = (step_cmds.size() > 0) ? step_cmds.size() : 1;
         for (int k = 0; k < n; k++) begin
            s.command = (k < step_cmds.size()) ? step_cmds[k] : CMD_NONE;
            s.last = (k == n - 1);
            s.phase = seq_phase;
            s.mode = seq_mode;
            s.warning = step_warn;
            awaited_status.push_back(s);
         end
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic logic [TIME_W-1:0] draw_time();
      // mostly real times of day, now and then raw values over the full field width
      if ($urandom_range(0, 9) == 0)
         return TIME_W'($urandom_range(0, 2 ** TIME_W - 1));
      return TIME_W'($urandom_range(0, DAY_LAST));
   endfunction

   task automatic plan(logic [1:0] kind, logic [2:0] action, logic shut, logic parked,
                       logic wx, logic [TIME_W-1:0] now, logic [TIME_W-1:0] sset,
                       logic [TIME_W-1:0] srise);
      plan_row_type row;
      row.r.kind = kind;
      row.r.action = action;
      row.r.shutter_closed = shut;
      row.r.mount_parked = parked;
      row.r.weather_ok = wx;
      row.r.time_now = now;
      row.r.sunset_time = sset;
      row.r.sunrise_time = srise;
      row.pinned = 1'b0;
      row.want = '0;
      rows.push_back(row);
   endtask

   // Type in the single response of the row planned last.
   task automatic pin(logic [3:0] cmd, logic [3:0] ph, logic [2:0] md, logic [1:0] wn);
      plan_row_type row;
      row = rows.pop_back();
      row.pinned = 1'b1;
      row.want.command = cmd;
      row.want.last = 1'b1;
      row.want.phase = ph;
      row.want.mode = md;
      row.want.warning = wn;
      rows.push_back(row);
   endtask

   // Present one request after a random gap and hold it until the block takes it.
   task automatic send_request(req_type r, bit keep);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= r.kind;
      req_tdata <= {7'b0, r.sunrise_time, r.sunset_time, r.time_now, r.weather_ok,
                    r.mount_parked, r.shutter_closed, r.action};
      do @(posedge clock); while (!req_tready);
      predict_request(r, keep);
   endtask

   task automatic write_register(logic [2:0] idx, logic [16:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_HAS_DOME:           model_cfg.has_dome = value[0];
         REG_HAS_MOUNT:          model_cfg.has_mount = value[0];
         REG_WEATHER_MUST_BE_OK: model_cfg.weather_must_be_ok = value[0];
         REG_TIME_RULE:          model_cfg.time_rule = value[1:0];
         REG_FIXED_START:        model_cfg.fixed_start = value;
         REG_FIXED_END:          model_cfg.fixed_end = value;
         default: ;
      endcase
   endtask

   // Drop the request valid and wait until every owed response has come back.
   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
   endtask

   task automatic apply_setup(cfg_type c);
      drain_requests();
      write_register(REG_HAS_DOME, 17'(c.has_dome));
      write_register(REG_HAS_MOUNT, 17'(c.has_mount));
      write_register(REG_WEATHER_MUST_BE_OK, 17'(c.weather_must_be_ok));
      write_register(REG_TIME_RULE, 17'(c.time_rule));
      write_register(REG_FIXED_START, c.fixed_start);
      write_register(REG_FIXED_END, c.fixed_end);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch at response %0d: %s expected %0d got %0d",
                  checked_count, what, want, got);
   endtask

   always @(posedge clock) begin : watch_responses
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_status.size() == 0) begin
            report_mismatch("response with nothing outstanding, tdata", 0, rsp_tdata);
         end else begin
            want = awaited_status.pop_front();
            if (rsp_tdata[3:0] !== want.command)
               report_mismatch("command", want.command, rsp_tdata[3:0]);
            if (rsp_tlast !== want.last)
               report_mismatch("tlast", want.last, rsp_tlast);
            if (rsp_tdata[7:4] !== want.phase)
               report_mismatch("phase", want.phase, rsp_tdata[7:4]);
            if (rsp_tdata[10:8] !== want.mode)
               report_mismatch("mode", want.mode, rsp_tdata[10:8]);
            if (rsp_tdata[12:11] !== want.warning)
               report_mismatch("warning", want.warning, rsp_tdata[12:11]);
            if (rsp_tdata[15:13] !== 3'b000)
               report_mismatch("padding", 0, rsp_tdata[15:13]);
         end
         seen_cmd[rsp_tdata[3:0]] = 1'b1;
         seen_phase[rsp_tdata[7:4]] = 1'b1;
         checked_count++;
         // stall the next response for a random number of cycles
         rsp_hold = calm ? 0 : $urandom_range(0, 3);
      end
   end

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Give up once nothing has moved on any channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("testbench: timeout after %0d quiet cycles", QUIET_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence

   initial begin : run
      cfg_type c;
      req_type r;
      int      useful;
      int      pick;
      int      cmd_kinds;
      int      phase_kinds;

      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_hold = 0;
      calm = 1'b0;
      model_cfg = '0;
      seq_mode = MODE_IDLE;
      seq_phase = PH_IDLE;
      seq_home = 1'b0;

      // Directed part. With every register at zero after reset: requests that need
      // devices, an abort with no device, a home event without mount, unknown codes.
      plan(KIND_TICK, ACT_OPEN, 0, 0, 0, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NONE);
      plan(KIND_ACTION, ACT_OPEN, 0, 0, 1, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NO_DEVICES);
      plan(KIND_ACTION, ACT_CLOSE, 0, 0, 1, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NO_DEVICES);
      plan(KIND_ACTION, ACT_ABORT, 0, 0, 1, '0, '0, '0);
      pin(CMD_NONE, PH_EMERGENCY, MODE_ABORT, WARN_NONE);
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NONE);
      plan(KIND_HOME, ACT_OPEN, 0, 0, 1, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NONE);
      plan(KIND_UNUSED, ACT_UNUSED_MAX, 1, 1, 1, TIME_ALL_ONES, TIME_ALL_ONES, TIME_ALL_ONES);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NONE);
      plan(KIND_ACTION, ACT_UNUSED_MAX, 0, 0, 1, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NONE);
      // From SETUP_ROW on: both devices, weather required, fixed window wrapping
      // past midnight. Walk a full auto open and close, a refused open, then a double abort.
      plan(KIND_ACTION, ACT_AUTO, 0, 0, 1, '0, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 1, 1, 1, TIME_ALL_ONES, '0, '0);   // raw time in window
      plan(KIND_TICK, ACT_OPEN, 0, 1, 1, '0, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 1, 1, '0, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, '0, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, '0, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, 17'd40000, '0, '0);       // leaves the window
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, 17'd40000, '0, '0);
      plan(KIND_HOME, ACT_OPEN, 0, 0, 1, '0, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, 17'd40000, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 0, 1, 17'd40000, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 1, 1, 17'd40000, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 0, 1, 1, 17'd40000, '0, '0);
      plan(KIND_TICK, ACT_OPEN, 1, 1, 1, 17'd40000, '0, '0);
      plan(KIND_ACTION, ACT_OPEN, 1, 1, 0, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_WEATHER_REFUSED);
      plan(KIND_ACTION, ACT_ABORT, 1, 1, 1, '0, '0, '0);
      pin(CMD_NONE, PH_EMERGENCY, MODE_ABORT, WARN_NONE);
      plan(KIND_TICK, ACT_OPEN, 1, 1, 1, '0, '0, '0);              // aborts both devices
      plan(KIND_ACTION, ACT_IDLE, 1, 1, 1, '0, '0, '0);
      pin(CMD_NONE, PH_IDLE, MODE_IDLE, WARN_NONE);

      // hold reset, then release it on a falling edge
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         if (i == SETUP_ROW) begin
            c = '0;
            c.has_dome = 1'b1;
            c.has_mount = 1'b1;
            c.weather_must_be_ok = 1'b1;
            c.time_rule = RULE_FIXED;
            c.fixed_start = 17'd80000;
            c.fixed_end = 17'd3600;
            apply_setup(c);
         end
         send_request(rows[i].r, !rows[i].pinned);
         if (rows[i].pinned)
            awaited_status.push_back(rows[i].want);
         directed_count++;
      end

      // Random part: several register settings, extremes first, then random ones.
      for (int s = 0; s < SETTING_COUNT; s++) begin
         c.has_dome = 1'($urandom_range(0, 1));
         c.has_mount = 1'($urandom_range(0, 1));
         c.weather_must_be_ok = 1'($urandom_range(0, 1));
         c.time_rule = 2'($urandom_range(0, 3));
         c.fixed_start = 17'($urandom_range(0, DAY_LAST));
         c.fixed_end = 17'($urandom_range(0, DAY_LAST));
         case (s)
            0: begin
               c.has_dome = 1'b1;
               c.has_mount = 1'b1;
               c.weather_must_be_ok = 1'b1;
               c.time_rule = RULE_ANYTIME;
            end
            1: begin
               // narrowest wrap: window from the last second of the day to midnight
               c.has_dome = 1'b1;
               c.has_mount = 1'b1;
               c.weather_must_be_ok = 1'b1;
               c.time_rule = RULE_FIXED;
               c.fixed_start = 17'(DAY_LAST);
               c.fixed_end = '0;
            end
            2: c = '0;
            3: begin
               c.has_dome = 1'b0;
               c.has_mount = 1'b1;
               c.time_rule = RULE_FIXED;
               c.fixed_start = '0;
               c.fixed_end = 17'(DAY_LAST);
            end
            4: begin
               c.has_dome = 1'b1;
               c.has_mount = 1'b0;
               c.weather_must_be_ok = 1'b1;
               c.time_rule = RULE_DUSK_DAWN;
            end
            default: ;
         endcase
         apply_setup(c);

         useful = 0;
         while (useful < ITEMS_PER_SETTING) begin
            // switch idling on and off in stretches
            if ($urandom_range(0, 39) == 0)
               calm = ($urandom_range(0, 2) == 0);
            // mostly ticks so that sequences run to the end; actions are rare
            pick = $urandom_range(0, 99);
            r.action = 3'($urandom_range(0, 7));
            r.shutter_closed = 1'($urandom_range(0, 1));
            r.mount_parked = 1'($urandom_range(0, 1));
            r.weather_ok = ($urandom_range(0, 9) != 0);
            r.time_now = draw_time();
            r.sunset_time = draw_time();
            r.sunrise_time = draw_time();
            if (pick < 80) begin
               r.kind = KIND_TICK;
            end else if (pick < 88) begin
               r.kind = KIND_HOME;
            end else if (pick < 98) begin
               r.kind = KIND_ACTION;
               pick = $urandom_range(0, 99);
               if (pick < 30)
                  r.action = ACT_AUTO;
               else if (pick < 55)
                  r.action = ACT_OPEN;
               else if (pick < 75)
                  r.action = ACT_CLOSE;
               else if (pick < 85)
                  r.action = ACT_ABORT;
               else if (pick < 93)
                  r.action = ACT_IDLE;
               else
                  r.action = 3'($urandom_range(ACT_UNUSED_MIN, ACT_UNUSED_MAX));
            end else begin
               r.kind = KIND_UNUSED;
            end
            send_request(r, 1'b1);
            random_count++;
            // ignored requests do not count toward the setting's share
            if (!(r.kind == KIND_UNUSED || (r.kind == KIND_ACTION && r.action > ACT_IDLE)))
               useful++;
         end
      end

      // let the last responses come back, then allow a few quiet cycles
      calm = 1'b1;
      drain_requests();
      repeat (TAIL_CYCLES) @(posedge clock);

      cmd_kinds = 0;
      phase_kinds = 0;
      for (int k = 0; k < 16; k++) begin
         cmd_kinds += seen_cmd[k];
         phase_kinds += seen_phase[k];
      end
      $display("testbench: %0d requests (%0d directed, %0d random) under %0d register settings",
               directed_count + random_count, directed_count, random_count, settings_count);
      $display("testbench: %0d responses checked, %0d command codes and %0d phases seen",
               checked_count, cmd_kinds, phase_kinds);
      if (mismatches == 0 && awaited_status.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: %0d mismatches, %0d responses missing",
                  mismatches, awaited_status.size());
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// File: observatory_open_close_sequencer.f
src/oocs_pkg.sv
src/oocs_step.sv
src/oocs_rsp_buf.sv
src/observatory_open_close_sequencer.sv
src/oocs_checker.sv
sim/testbench.sv
